### hw/rtl/twhsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twhsm_pkg
// Types, codes and pin tables shared by the two-wire sensor master.
// ----------------------------------------------------------------------------
package twhsm_pkg;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_TEMP = 3'd1;
  localparam logic [2:0] CMD_HUMI = 3'd2;
  localparam logic [2:0] CMD_SOFT = 3'd3;
  localparam logic [2:0] CMD_CONN = 3'd4;

  localparam logic [2:0] REG_TEMP_CODE    = 3'd0;
  localparam logic [2:0] REG_HUMI_CODE    = 3'd1;
  localparam logic [2:0] REG_RESET_CODE   = 3'd2;
  localparam logic [2:0] REG_READY_TMO    = 3'd3;
  localparam logic [2:0] REG_RESET_WAIT   = 3'd4;

  localparam logic [3:0] RESET_CLOCKS = 4'd9;
  localparam logic [3:0] BYTE_BITS    = 4'd8;
  localparam logic [1:0] READ_BYTES   = 2'd3;
  localparam logic [2:0] START_LAST   = 3'd5;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_CLOCKS = 9'b000000010,
    PH_START  = 9'b000000100,
    PH_WRITE  = 9'b000001000,
    PH_WACK   = 9'b000010000,
    PH_READY  = 9'b000100000,
    PH_READ   = 9'b001000000,
    PH_RACK   = 9'b010000000,
    PH_RWAIT  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic       data_line_in;
  } in_t;

  typedef struct packed {
    logic        clock_line;
    logic        data_line_out;
    logic        data_line_enable;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measured_value;
    logic [7:0]  checksum_byte;
    logic        no_acknowledge;
    logic        ready_timeout;
  } out_t;

  typedef struct packed {
    logic [7:0]  temp_code;
    logic [7:0]  humi_code;
    logic [7:0]  reset_code;
    logic [15:0] ready_timeout_ticks;
    logic [7:0]  reset_wait_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  sub_step;
    logic [3:0]  bit_counter;
    logic [1:0]  byte_counter;
    logic [7:0]  shift_reg;
    logic [15:0] value_reg;
    logic [7:0]  checksum_reg;
    logic [1:0]  error_flags;
    logic [15:0] wait_counter;
    logic [2:0]  pending_cmd;
  } state_t;

  // start condition pins, {clock, data} per tick
  function automatic logic [1:0] start_pins(input logic [2:0] step);
    logic [1:0] pins;
    case (step)
      3'd0:    pins = 2'b01;
      3'd1:    pins = 2'b11;
      3'd2:    pins = 2'b10;
      3'd3:    pins = 2'b00;
      3'd4:    pins = 2'b10;
      3'd5:    pins = 2'b11;
      3'd6:    pins = 2'b01;
      default: pins = 2'b11;
    endcase
    return pins;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/twhsm_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twhsm_step
// One tick of the bus sequencer: next state and pin/status beat.
// ----------------------------------------------------------------------------
module twhsm_step import twhsm_pkg::*; (
  input  var state_t st,
  input  var cfg_t   cfg,
  input  var in_t    item,
  output state_t     st_next,
  output out_t       res
);

  always_comb begin
    state_t s;
    logic   clk_l;
    logic   dout;
    logic   oe;
    logic   busy;
    logic   fin;
    logic [7:0] sh;

    s = st;
    clk_l = 1'b0;
    dout = 1'b1;
    oe = 1'b0;
    busy = 1'b0;
    fin = 1'b0;
    sh = '0;

    if (s.phase == PH_IDLE &&
        (item.command == CMD_TEMP || item.command == CMD_HUMI ||
         item.command == CMD_SOFT || item.command == CMD_CONN)) begin
      s.pending_cmd = item.command;
      s.error_flags = '0;
      s.sub_step = '0;
      s.bit_counter = '0;
      s.byte_counter = '0;
      s.wait_counter = '0;
      s.phase = (item.command == CMD_TEMP || item.command == CMD_HUMI) ?
                PH_START : PH_CLOCKS;
    end

    if (s.phase != PH_IDLE) begin
      busy = 1'b1;
      case (s.phase)
        PH_CLOCKS: begin
          oe = 1'b1;
          clk_l = (s.sub_step == 3'd0);
          if (s.sub_step == 3'd0) begin
            s.sub_step = 3'd1;
          end else begin
            s.sub_step = '0;
            s.bit_counter = s.bit_counter + 4'd1;
            if (s.bit_counter >= RESET_CLOCKS) begin
              s.bit_counter = '0;
              s.phase = PH_START;
            end
          end
        end
        PH_START: begin
          oe = 1'b1;
          {clk_l, dout} = start_pins(s.sub_step);
          if (s.sub_step < START_LAST) begin
            s.sub_step = s.sub_step + 3'd1;
          end else begin
            s.sub_step = '0;
            if (s.pending_cmd == CMD_CONN) begin
              fin = 1'b1;
            end else begin
              s.bit_counter = '0;
              s.shift_reg = (s.pending_cmd == CMD_TEMP) ? cfg.temp_code :
                            (s.pending_cmd == CMD_HUMI) ? cfg.humi_code :
                            cfg.reset_code;
              s.phase = PH_WRITE;
            end
          end
        end
        PH_WRITE: begin
          oe = 1'b1;
          dout = s.shift_reg[7];
          clk_l = (s.sub_step == 3'd1);
          if (s.sub_step < 3'd2) begin
            s.sub_step = s.sub_step + 3'd1;
          end else begin
            s.sub_step = '0;
            s.shift_reg = {s.shift_reg[6:0], 1'b0};
            s.bit_counter = s.bit_counter + 4'd1;
            if (s.bit_counter >= BYTE_BITS) begin
              s.bit_counter = '0;
              s.phase = PH_WACK;
            end
          end
        end
        PH_WACK: begin
          clk_l = 1'b1;
          if (item.data_line_in) begin
            s.error_flags[0] = 1'b1;
          end
          s.wait_counter = '0;
          if (s.pending_cmd == CMD_SOFT) begin
            if (cfg.reset_wait_ticks == 8'd0) begin
              fin = 1'b1;
            end else begin
              s.phase = PH_RWAIT;
            end
          end else begin
            s.phase = PH_READY;
          end
        end
        PH_READY: begin
          if (item.data_line_in) begin
            s.wait_counter = s.wait_counter + 16'd1;
          end
          if (!item.data_line_in || s.wait_counter >= cfg.ready_timeout_ticks) begin
            if (item.data_line_in) begin
              s.error_flags[1] = 1'b1;
            end
            s.phase = PH_READ;
            s.sub_step = '0;
            s.bit_counter = '0;
            s.byte_counter = '0;
            s.shift_reg = '0;
          end
        end
        PH_READ: begin
          clk_l = (s.sub_step == 3'd1);
          if (s.sub_step == 3'd0) begin
            s.sub_step = 3'd1;
          end else begin
            s.sub_step = '0;
            sh = {s.shift_reg[6:0], item.data_line_in};
            s.shift_reg = sh;
            s.bit_counter = s.bit_counter + 4'd1;
            if (s.bit_counter >= BYTE_BITS) begin
              s.bit_counter = '0;
              case (s.byte_counter)
                2'd0:    s.value_reg[15:8] = sh;
                2'd1:    s.value_reg[7:0] = sh;
                default: s.checksum_reg = sh;
              endcase
              s.shift_reg = '0;
              s.phase = PH_RACK;
            end
          end
        end
        PH_RACK: begin
          oe = 1'b1;
          dout = (s.byte_counter >= 2'd2);
          clk_l = (s.sub_step == 3'd1);
          if (s.sub_step < 3'd2) begin
            s.sub_step = s.sub_step + 3'd1;
          end else begin
            s.sub_step = '0;
            s.byte_counter = s.byte_counter + 2'd1;
            if (s.byte_counter >= READ_BYTES) begin
              s.byte_counter = '0;
              fin = 1'b1;
            end else begin
              s.phase = PH_READ;
            end
          end
        end
        PH_RWAIT: begin
          s.wait_counter = s.wait_counter + 16'd1;
          if (s.wait_counter >= {8'd0, cfg.reset_wait_ticks}) begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
      if (fin) begin
        s.phase = PH_IDLE;
        s.sub_step = '0;
        s.bit_counter = '0;
        s.byte_counter = '0;
      end
    end

    st_next = s;
    res.clock_line = clk_l;
    res.data_line_out = dout;
    res.data_line_enable = oe;
    res.busy_res = busy;
    res.done_res = fin;
    res.measured_value = s.value_reg;
    res.checksum_byte = s.checksum_reg;
    res.no_acknowledge = s.error_flags[0];
    res.ready_timeout = s.error_flags[1];
  end

endmodule
`default_nettype wire

### hw/rtl/two_wire_humidity_sensor_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_wire_humidity_sensor_master
// Tick-driven master for a two-wire humidity and temperature sensor bus.
// ----------------------------------------------------------------------------
// Each input beat is one bus tick carrying an optional command and the sampled
// data line; each accepted tick yields exactly one output beat with the pin
// levels for that tick, busy/done status, the measured value, checksum and
// error flags. One tick is taken every clock cycle unless stalled: the
// sequencer step is a single pass of logic from the state registers to the
// output register, and a one-entry skid stage lets a tick enter while the
// previous beat is still stalled at the output. in_stall rises only when
// both output slots are full. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and must only be changed while no sequence is running.
module two_wire_humidity_sensor_master import twhsm_pkg::*; (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        cfg_we,
  input  var logic [2:0]  cfg_index,
  input  var logic [15:0] cfg_data,
  input  var logic        in_valid,
  output logic            in_stall,
  input  var in_t         in_data,
  output logic            out_valid,
  input  var logic        out_stall,
  output out_t            out_data
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  out_t   res;
  out_t   skid_data;
  logic   skid_valid;
  logic   in_acc;
  logic   out_take;

  assign in_stall = skid_valid;
  assign in_acc = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  twhsm_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_data),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_code <= 8'd3;
      cfg.humi_code <= 8'd5;
      cfg.reset_code <= 8'd30;
      cfg.ready_timeout_ticks <= 16'hFFFF;
      cfg.reset_wait_ticks <= 8'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CODE:  cfg.temp_code <= cfg_data[7:0];
        REG_HUMI_CODE:  cfg.humi_code <= cfg_data[7:0];
        REG_RESET_CODE: cfg.reset_code <= cfg_data[7:0];
        REG_READY_TMO:  cfg.ready_timeout_ticks <= cfg_data;
        REG_RESET_WAIT: cfg.reset_wait_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
      st.sub_step <= '0;
      st.bit_counter <= '0;
      st.byte_counter <= '0;
      st.shift_reg <= '0;
      st.value_reg <= '0;
      st.checksum_reg <= '0;
      st.error_flags <= '0;
      st.wait_counter <= '0;
      st.pending_cmd <= CMD_NONE;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (in_acc) begin
      if (out_valid && !out_take) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done beat without busy");

  a_released_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.data_line_enable |-> out_data.data_line_out)
    else $error("released data line not high");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full with output empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !skid_valid)
    else $error("output not empty after reset");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.busy_res |-> !out_data.clock_line && !out_data.data_line_enable)
    else $error("pins driven while idle");
`endif

endmodule
`default_nettype wire

### verif/two_wire_humidity_sensor_master_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_wire_humidity_sensor_master_tb
// Self-checking bench for the tick-driven two-wire sensor bus master.
// ----------------------------------------------------------------------------
// A model of the sequencer inside a small tracker class predicts the pin
// levels, status, value and flags of every tick, and each output beat is
// compared with the oldest prediction. Directed sequences cover every command,
// ignored codes, missing acknowledge, ready timeouts at short and mid limits
// and a zero reset wait; random sequences follow, mostly well formed with a
// share of noisy data. Both handshake sides idle at random, the receiver holds
// off once for a long stretch, and registers are rewritten between sequences.
// ----------------------------------------------------------------------------
module two_wire_humidity_sensor_master_tb;
  import twhsm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_TICKS   = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 400;
  localparam int CMD_CODE_MAX   = 7;
  localparam int SEQS_PER_CFG   = 4;

  // start condition pins, bit i is tick i
  localparam logic [5:0] START_CLOCK = 6'b110110;
  localparam logic [5:0] START_DATA  = 6'b100011;

  typedef enum int {READ_RANDOM, READ_ONES, READ_ZEROS} read_mode_t;

  typedef struct {
    int         ready_high;
    read_mode_t read_mode;
    int         noise_pct;
    int         busy_cmd_pct;
    bit         bad_ack;
    bit         no_gaps;
    int         pause_at;
  } seq_knobs_t;

  class sensor_bus_tracker;
    logic [7:0]  temp_code   = 8'd3;
    logic [7:0]  humi_code   = 8'd5;
    logic [7:0]  reset_code  = 8'd30;
    logic [15:0] ready_limit = 16'hFFFF;
    logic [7:0]  reset_wait  = 8'd15;

    phase_t      phase    = PH_IDLE;
    logic [2:0]  sub_cnt  = '0;
    logic [3:0]  bit_cnt  = '0;
    logic [1:0]  byte_cnt = '0;
    logic [7:0]  shreg    = '0;
    logic [15:0] value    = '0;
    logic [7:0]  cks      = '0;
    logic [1:0]  flags    = '0;
    logic [15:0] waitc    = '0;
    logic [2:0]  pend     = '0;

    out_t pin_levels_due[$];
    int   errors = 0;

    function void set_register(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_TEMP_CODE:  temp_code   = val[7:0];
        REG_HUMI_CODE:  humi_code   = val[7:0];
        REG_RESET_CODE: reset_code  = val[7:0];
        REG_READY_TMO:  ready_limit = val;
        REG_RESET_WAIT: reset_wait  = val[7:0];
        default: ;
      endcase
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return pin_levels_due.size();
    endfunction

    function out_t bus_tick(in_t t);
      out_t r;
      logic fin;
      logic din;
      logic go;
      r = '0;
      r.data_line_out = 1'b1;
      fin = 1'b0;
      din = t.data_line_in;
      if (phase == PH_IDLE && t.command >= CMD_TEMP && t.command <= CMD_CONN) begin
        pend = t.command;
        flags = '0;
        sub_cnt = '0;
        bit_cnt = '0;
        byte_cnt = '0;
        waitc = '0;
        phase = (t.command <= CMD_HUMI) ? PH_START : PH_CLOCKS;
      end
      if (phase != PH_IDLE) begin
        r.busy_res = 1'b1;
        case (phase)
          PH_CLOCKS: begin
            r.data_line_enable = 1'b1;
            r.clock_line = (sub_cnt == 0);
            if (sub_cnt == 0) begin
              sub_cnt = 1;
            end else begin
              sub_cnt = 0;
              bit_cnt++;
              if (bit_cnt >= RESET_CLOCKS) begin
                bit_cnt = 0;
                phase = PH_START;
              end
            end
          end
          PH_START: begin
            r.data_line_enable = 1'b1;
            r.clock_line = START_CLOCK[sub_cnt];
            r.data_line_out = START_DATA[sub_cnt];
            if (sub_cnt < START_LAST) begin
              sub_cnt++;
            end else begin
              sub_cnt = 0;
              if (pend == CMD_CONN) begin
                fin = 1'b1;
              end else begin
                bit_cnt = 0;
                shreg = (pend == CMD_TEMP) ? temp_code :
                        (pend == CMD_HUMI) ? humi_code : reset_code;
                phase = PH_WRITE;
              end
            end
          end
          PH_WRITE: begin
            r.data_line_enable = 1'b1;
            r.data_line_out = shreg[7];
            r.clock_line = (sub_cnt == 1);
            if (sub_cnt < 2) begin
              sub_cnt++;
            end else begin
              sub_cnt = 0;
              shreg = shreg << 1;
              bit_cnt++;
              if (bit_cnt >= BYTE_BITS) begin
                bit_cnt = 0;
                phase = PH_WACK;
              end
            end
          end
          PH_WACK: begin
            r.clock_line = 1'b1;
            if (din) flags[0] = 1'b1;
            waitc = '0;
            if (pend == CMD_SOFT) begin
              if (reset_wait == 0) fin = 1'b1;
              else phase = PH_RWAIT;
            end else begin
              phase = PH_READY;
            end
          end
          PH_READY: begin
            go = 1'b1;
            if (din) begin
              waitc = waitc + 16'd1;
              if (waitc < ready_limit) go = 1'b0;
              else flags[1] = 1'b1;
            end
            if (go) begin
              phase = PH_READ;
              sub_cnt = 0;
              bit_cnt = 0;
              byte_cnt = 0;
              shreg = '0;
            end
          end
          PH_READ: begin
            r.clock_line = (sub_cnt == 1);
            if (sub_cnt == 0) begin
              sub_cnt = 1;
            end else begin
              sub_cnt = 0;
              shreg = {shreg[6:0], din};
              bit_cnt++;
              if (bit_cnt >= BYTE_BITS) begin
                bit_cnt = 0;
                case (byte_cnt)
                  2'd0:    value[15:8] = shreg;
                  2'd1:    value[7:0] = shreg;
                  default: cks = shreg;
                endcase
                shreg = '0;
                phase = PH_RACK;
              end
            end
          end
          PH_RACK: begin
            r.data_line_enable = 1'b1;
            r.data_line_out = (byte_cnt < 2) ? 1'b0 : 1'b1;
            r.clock_line = (sub_cnt == 1);
            if (sub_cnt < 2) begin
              sub_cnt++;
            end else begin
              sub_cnt = 0;
              byte_cnt++;
              if (byte_cnt >= READ_BYTES) begin
                byte_cnt = 0;
                fin = 1'b1;
              end else begin
                phase = PH_READ;
              end
            end
          end
          PH_RWAIT: begin
            waitc = waitc + 16'd1;
            if (waitc >= reset_wait) fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          r.done_res = 1'b1;
          phase = PH_IDLE;
          sub_cnt = 0;
          bit_cnt = 0;
          byte_cnt = 0;
        end
      end
      r.measured_value = value;
      r.checksum_byte = cks;
      r.no_acknowledge = flags[0];
      r.ready_timeout = flags[1];
      return r;
    endfunction

    function void note_tick(in_t t);
      pin_levels_due.push_back(bus_tick(t));
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pin_levels_due.size() == 0) begin
        $error("output beat with nothing pending");
        errors++;
        return;
      end
      want = pin_levels_due.pop_front();
      field_check("clock_line", want.clock_line, got.clock_line);
      field_check("data_line_out", want.data_line_out, got.data_line_out);
      field_check("data_line_enable", want.data_line_enable, got.data_line_enable);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("done_res", want.done_res, got.done_res);
      field_check("measured_value", want.measured_value, got.measured_value);
      field_check("checksum_byte", want.checksum_byte, got.checksum_byte);
      field_check("no_acknowledge", want.no_acknowledge, got.no_acknowledge);
      field_check("ready_timeout", want.ready_timeout, got.ready_timeout);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  sensor_bus_tracker tracker = new();
  int ticks_sent   = 0;
  int result_beats = 0;
  int stuck        = 0;
  bit held_long    = 1'b0;

  two_wire_humidity_sensor_master u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic seq_knobs_t plain_knobs(int ready_high);
    seq_knobs_t k;
    k.ready_high = ready_high;
    k.read_mode = READ_RANDOM;
    k.noise_pct = 0;
    k.busy_cmd_pct = 0;
    k.bad_ack = 1'b0;
    k.no_gaps = 1'b0;
    k.pause_at = -1;
    return k;
  endfunction

  task automatic send_tick(input in_t t, input bit no_gap);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = t;
    do @(posedge clk); while (in_stall);
    tracker.note_tick(in_data);
    ticks_sent++;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = 4'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    tracker.set_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] temp, input logic [7:0] humi,
                              input logic [7:0] rcode, input logic [15:0] tmo,
                              input logic [7:0] rwait);
    write_reg(REG_TEMP_CODE, {8'h00, temp});
    write_reg(REG_HUMI_CODE, {8'h00, humi});
    write_reg(REG_RESET_CODE, {8'h00, rcode});
    write_reg(REG_READY_TMO, tmo);
    write_reg(REG_RESET_WAIT, {8'h00, rwait});
  endtask

  task automatic run_sequence(input logic [2:0] cmd, input seq_knobs_t k);
    int   ready_left;
    int   n;
    in_t  t;
    ready_left = k.ready_high;
    n = 0;
    t.command = cmd;
    t.data_line_in = 1'($urandom_range(1));
    send_tick(t, k.no_gaps);
    while (!tracker.is_idle()) begin
      n++;
      if (n == k.pause_at) settle();
      t.command = ($urandom_range(99) < k.busy_cmd_pct) ?
                  3'($urandom_range(CMD_CODE_MAX)) : CMD_NONE;
      case (tracker.phase)
        PH_WACK: t.data_line_in = k.bad_ack;
        PH_READY: begin
          if (ready_left > 0) begin
            t.data_line_in = 1'b1;
            ready_left--;
          end else begin
            t.data_line_in = 1'b0;
          end
        end
        PH_READ: begin
          case (k.read_mode)
            READ_ONES:  t.data_line_in = 1'b1;
            READ_ZEROS: t.data_line_in = 1'b0;
            default:    t.data_line_in = 1'($urandom_range(1));
          endcase
        end
        default: t.data_line_in = 1'($urandom_range(1));
      endcase
      if ($urandom_range(99) < k.noise_pct) t.data_line_in = 1'($urandom_range(1));
      send_tick(t, k.no_gaps);
    end
  endtask

  // output monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stuck = 0;
    end else begin
      if (out_valid && !out_stall) begin
        tracker.check_result(out_data);
        result_beats++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= WATCHDOG_LIMIT) begin
          $display("two_wire_humidity_sensor_master_tb: errors");
          $finish;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int len;
    int r;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_long && result_beats >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_stall = 1'b1;
        len = LONG_HOLD;
      end else begin
        r = $urandom_range(99);
        if (r < 50) begin
          out_stall = 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 80) begin
          out_stall = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall = 1'b0;
          len = $urandom_range(20, 100);
        end else begin
          out_stall = 1'b1;
          len = $urandom_range(10, 40);
        end
      end
      repeat (len) @(negedge clk);
    end
  end

  initial begin
    seq_knobs_t k;
    logic [2:0] cmd;
    int random_start;
    int seq_no;
    int r;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset register values
    run_sequence(CMD_TEMP, plain_knobs(3));
    k = plain_knobs(0);
    k.read_mode = READ_ONES;
    run_sequence(CMD_HUMI, k);
    run_sequence(CMD_SOFT, plain_knobs(0));
    run_sequence(CMD_CONN, plain_knobs(0));
    run_sequence(CMD_NONE, plain_knobs(0));
    for (int c = CMD_CONN + 1; c <= CMD_CODE_MAX; c++) run_sequence(3'(c), plain_knobs(0));

    // commands while busy are ignored, sender drains mid sequence
    k = plain_knobs(2);
    k.busy_cmd_pct = 100;
    k.pause_at = 20;
    run_sequence(CMD_TEMP, k);

    // missing acknowledge
    k = plain_knobs(1);
    k.bad_ack = 1'b1;
    k.read_mode = READ_ZEROS;
    run_sequence(CMD_HUMI, k);
    k = plain_knobs(0);
    k.bad_ack = 1'b1;
    run_sequence(CMD_SOFT, k);

    // data ready never comes within the timeout
    settle();
    write_reg(REG_READY_TMO, 16'd40);
    k = plain_knobs(100);
    k.no_gaps = 1'b1;
    run_sequence(CMD_HUMI, k);

    // low extremes, zero reset wait
    settle();
    apply_config(8'h00, 8'hFF, 8'h00, 16'd1, 8'd0);
    run_sequence(CMD_TEMP, plain_knobs(0));
    run_sequence(CMD_TEMP, plain_knobs(5));
    run_sequence(CMD_SOFT, plain_knobs(0));
    run_sequence(CMD_HUMI, plain_knobs(1));

    // high extremes, timeout one short and exactly reached
    settle();
    apply_config(8'hFF, 8'h00, 8'hFF, 16'd2, 8'd255);
    run_sequence(CMD_TEMP, plain_knobs(1));
    run_sequence(CMD_TEMP, plain_knobs(2));
    run_sequence(CMD_SOFT, plain_knobs(0));
    k = plain_knobs(0);
    k.read_mode = READ_ONES;
    run_sequence(CMD_HUMI, k);

    random_start = ticks_sent;
    seq_no = 0;
    while (ticks_sent - random_start < RANDOM_TICKS) begin
      if (seq_no % SEQS_PER_CFG == 0) begin
        settle();
        r = $urandom_range(3);
        if (r == 0) begin
          apply_config(8'h00, 8'h00, 8'h00, 16'd1, 8'd0);
        end else if (r == 1) begin
          apply_config(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'd255);
        end else begin
          apply_config(8'($urandom), 8'($urandom), 8'($urandom),
                       ($urandom_range(7) == 0) ? 16'($urandom_range(1, 65535)) :
                                                  16'($urandom_range(1, 30)),
                       8'($urandom_range(0, 40)));
        end
      end

      k = plain_knobs(($urandom_range(9) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(0, 12));
      k.no_gaps = ($urandom_range(9) < 3);
      k.pause_at = ($urandom_range(7) == 0) ? $urandom_range(1, 80) : -1;
      if ($urandom_range(99) < 80) begin
        k.noise_pct = $urandom_range(0, 5);
        k.bad_ack = ($urandom_range(9) == 0);
        k.busy_cmd_pct = ($urandom_range(1) == 0) ? 0 : 10;
        r = $urandom_range(9);
        k.read_mode = (r == 0) ? READ_ONES : (r == 1) ? READ_ZEROS : READ_RANDOM;
      end else begin
        k.noise_pct = $urandom_range(30, 100);
        k.bad_ack = 1'($urandom_range(1));
        k.busy_cmd_pct = $urandom_range(0, 50);
      end

      if ($urandom_range(99) < 85) cmd = 3'($urandom_range(CMD_TEMP, CMD_CONN));
      else cmd = ($urandom_range(1) == 0) ? CMD_NONE :
                 3'($urandom_range(CMD_CONN + 1, CMD_CODE_MAX));
      run_sequence(cmd, k);

      // a few idle ticks between sequences
      repeat ($urandom_range(0, 3)) run_sequence(CMD_NONE, plain_knobs(0));
      seq_no++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("two_wire_humidity_sensor_master_tb: clean");
    end else begin
      $display("two_wire_humidity_sensor_master_tb: errors");
    end
    $finish;
  end

endmodule
